### rtl/core/gf2_matrix_mult_accumulate_top_macros.svh
// assertion macros for the gf2 multiply-accumulate core
// clocked on clk, disabled during rst
`ifndef GF2_MATRIX_MULT_ACCUMULATE_TOP_MACROS_SVH
`define GF2_MATRIX_MULT_ACCUMULATE_TOP_MACROS_SVH

`define GF2MMA_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("gf2mma same-cycle check failed");

`define GF2MMA_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("gf2mma next-cycle check failed");

`endif

### rtl/core/gf2mma_pkg.sv
package gf2mma_pkg;

  localparam int ROW_W = 64;
  localparam int IDX_W = 6;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_MUL  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_INNER = 1'b0,
    CFG_NUM_COLS  = 1'b1
  } cfg_reg_t;

  // one slot of the cell chain; data is the B row on load, the running C row on multiply
  typedef struct packed {
    logic             valid;
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] data;
    logic             last;
  } item_t;

  function automatic logic [ROW_W-1:0] low_mask(input logic [CFG_W-1:0] bits);
    logic [ROW_W-1:0] m;
    m = '1;
    if (bits < CFG_W'(ROW_W)) begin
      m = ~({ROW_W{1'b1}} << bits[IDX_W-1:0]);
    end
    return m;
  endfunction

endpackage

### rtl/core/gf2_matrix_mult_accumulate_top.sv
// GF(2) row multiply-accumulate: result = (acc_row ^ XOR of B rows j with A bit j set) & cols.
// Input stream s_*: tuser selects load (B row into row register row_index) or multiply
// (row_bits is the A row, acc_row the C row); tlast marks the final A row.
// Output stream m_*: one transfer per multiply, none per load; tlast copies last_in.
// Config channel cfg_*: index 0 num_inner, index 1 num_cols; ready whenever rst is low, written while idle.
// The datapath is a chain of MAX_DIM cells, each holding one B row and folding in one A bit
// per cycle unless stalled; loads travel the chain too, so each item sees B exactly
// as ordered. An item passes the MAX_DIM cell registers in order, then the output register.
// Throughput: one item per cycle while s_tready is high, any mix of loads and multiplies.
// Reset clears the chain's valid bits and m_tvalid, and sets num_inner and num_cols to 64;
// B rows hold no reset value and must be loaded before use.
// When the receiver stalls, the result holds on m_*; the chain keeps moving until a
// multiply reaches its end, then s_tready drops until the waiting result is taken.
module gf2_matrix_mult_accumulate_top #(
  parameter int MAX_DIM = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [135:0]                   s_tdata,   // row_index, row_bits, acc_row, zero pad
  input  logic                           s_tuser,   // cmd
  input  logic                           s_tlast,   // last_in
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [63:0]                    m_tdata,   // result_row
  output logic                           m_tlast,   // last_out
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gf2mma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gf2mma_pkg::CFG_W-1:0]   cfg_data
);
  import gf2mma_pkg::*;

  `include "gf2_matrix_mult_accumulate_top_macros.svh"

  logic [CFG_W-1:0] num_inner;
  logic [CFG_W-1:0] num_cols;
  logic [CFG_W-1:0] inner_sat;
  logic [ROW_W-1:0] col_mask;
  item_t            head;
  item_t            chain [0:MAX_DIM];
  logic             end_mul;
  logic             advance;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_inner <= CFG_W'(ROW_W);
      num_cols  <= CFG_W'(ROW_W);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NUM_INNER: num_inner <= cfg_data;
        CFG_NUM_COLS:  num_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign inner_sat = (num_inner > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : num_inner;
  assign col_mask  = low_mask(num_cols);

  always_comb begin
    head.valid = s_tvalid && s_tready;
    head.cmd   = cmd_t'(s_tuser);
    head.idx   = s_tdata[5:0];
    head.a     = s_tdata[69:6] & low_mask(inner_sat);
    head.last  = s_tlast;
    if (cmd_t'(s_tuser) == CMD_LOAD) begin
      head.data = s_tdata[69:6] & col_mask;
    end else begin
      head.data = s_tdata[133:70];
    end
  end

  assign chain[0] = head;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    gf2mma_cell #(.INDEX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .prev    (chain[g]),
      .item    (chain[g+1])
    );
  end

  assign end_mul  = chain[MAX_DIM].valid && chain[MAX_DIM].cmd == CMD_MUL;
  assign advance  = !(end_mul && m_tvalid && !m_tready);
  assign s_tready = advance && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && end_mul) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && end_mul) begin
      m_tdata <= chain[MAX_DIM].data & col_mask;
      m_tlast <= chain[MAX_DIM].last;
    end
  end

  `GF2MMA_ASSERT_NEXT(a_result_lands, advance && end_mul, m_tvalid)
  `GF2MMA_ASSERT_NEXT(a_chain_holds, !advance, $stable(chain[MAX_DIM].data))
  `GF2MMA_ASSERT_IMP(a_cols_masked, m_tvalid, (m_tdata & ~col_mask) == '0)

endmodule

### rtl/core/gf2mma_cell.sv
module gf2mma_cell #(
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  gf2mma_pkg::item_t   prev,
  output gf2mma_pkg::item_t   item
);
  import gf2mma_pkg::*;

  logic [ROW_W-1:0] b_row;
  item_t            item_next;

  always_comb begin
    item_next = prev;
    item_next.a = prev.a >> 1;
    if (prev.cmd == CMD_MUL && prev.a[0]) begin
      item_next.data = prev.data ^ b_row;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && prev.valid && prev.cmd == CMD_LOAD && prev.idx == IDX_W'(INDEX)) begin
      b_row <= prev.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (advance) begin
      item.valid <= item_next.valid;
    end
    if (advance) begin
      item.cmd  <= item_next.cmd;
      item.idx  <= item_next.idx;
      item.a    <= item_next.a;
      item.data <= item_next.data;
      item.last <= item_next.last;
    end
  end

endmodule

### bench/tb_gf2_matrix_mult_accumulate_top.sv
`timescale 1ns / 100ps

module tb_gf2_matrix_mult_accumulate_top;
  import gf2mma_pkg::*;

  localparam int CHAIN_WAIT = 80;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 125;

  typedef struct {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] bits;
    logic [ROW_W-1:0] acc;
    logic             last;
  } row_item_t;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic             last;
  } c_row_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [135:0] s_tdata = '0;  // row_index, row_bits, acc_row, zero pad
  logic s_tuser = 1'b0;        // cmd
  logic s_tlast = 1'b0;        // last_in
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;        // result_row
  logic m_tlast;               // last_out
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  row_item_t pending_rows[$];
  row_item_t on_bus;
  c_row_t c_rows_due[$];
  logic [ROW_W-1:0] b_matrix [64];
  logic [63:0] b_loaded = '0;
  logic [CFG_W-1:0] inner_reg = 7'd64;
  logic [CFG_W-1:0] cols_reg = 7'd64;
  idle_mode_t idle_mode = IDLE_NONE;
  int errors = 0;
  int quiet_cycles = 0;

  gf2_matrix_mult_accumulate_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [ROW_W-1:0] col_mask(input logic [CFG_W-1:0] n);
    if (n >= 7'd64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic logic [CFG_W-1:0] inner_used();
    return (inner_reg > 7'd64) ? 7'd64 : inner_reg;
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = '1;
      2: r = 64'd1 << $urandom_range(0, 63);
      3: r = r & {$urandom, $urandom};
      default: ;
    endcase
    return r;
  endfunction

  // multiply only selects rows that were loaded; bits past the inner dimension stay free
  task automatic queue_row(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                           input logic [ROW_W-1:0] bits, input logic [ROW_W-1:0] acc,
                           input logic last);
    row_item_t it;
    it.cmd = cmd;
    it.idx = idx;
    it.bits = bits;
    it.acc = acc;
    it.last = last;
    if (cmd == CMD_LOAD) begin
      b_loaded[idx] = 1'b1;
    end else begin
      it.bits = bits & (b_loaded | ~col_mask(inner_used()));
    end
    pending_rows.push_back(it);
  endtask

  task automatic row_mac(input row_item_t it);
    c_row_t c;
    if (it.cmd == CMD_LOAD) begin
      b_matrix[it.idx] = it.bits & col_mask(cols_reg);
    end else begin
      c.row = it.acc;
      for (int j = 0; j < inner_used(); j++) begin
        if (it.bits[j]) c.row ^= b_matrix[j];
      end
      c.row &= col_mask(cols_reg);
      c.last = it.last;
      c_rows_due.push_back(c);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
                                 input logic [ROW_W-1:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit hold_off(input idle_mode_t busy_mode);
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 15;
    if (idle_mode == busy_mode) return $urandom_range(0, 99) < 81;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) row_mac(on_bus);
      if (!s_tvalid || s_tready) begin
        if (pending_rows.size() > 0 && !hold_off(IDLE_SEND)) begin
          on_bus = pending_rows.pop_front();
          s_tdata <= {2'b00, on_bus.acc, on_bus.bits, on_bus.idx};
          s_tuser <= on_bus.cmd;
          s_tlast <= on_bus.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    c_row_t c;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (c_rows_due.size() == 0) begin
          report_mismatch("result with none pending", m_tdata, '0);
        end else begin
          c = c_rows_due.pop_front();
          if (m_tdata !== c.row) report_mismatch("result_row", m_tdata, c.row);
          if (m_tlast !== c.last) begin
            report_mismatch("last_out", ROW_W'(m_tlast), ROW_W'(c.last));
          end
        end
      end
      m_tready <= !hold_off(IDLE_RECV);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (pending_rows.size() > 0 || s_tvalid || c_rows_due.size() > 0);
    repeat (CHAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    cfg_index <= r;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (r == CFG_NUM_INNER) inner_reg = v;
    else cols_reg = v;
  endtask

  task automatic random_rows(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        queue_row(CMD_LOAD, IDX_W'($urandom_range(0, 63)), rand_row(), rand_row(), 1'b0);
      end else begin
        queue_row(CMD_MUL, IDX_W'($urandom), rand_row(), rand_row(),
                  $urandom_range(0, 7) == 0);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] inner_set [6];
    logic [CFG_W-1:0] cols_set [6];
    idle_mode_t mode_set [6];

    inner_set = '{7'd64, 7'd1, 7'd64, 7'd17, 7'd0, 7'd64};
    cols_set = '{7'd64, 7'd64, 7'd1, 7'd40, 7'd0, 7'd64};
    mode_set = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_SEND, IDLE_RECV};
    inner_set[4] = 7'($urandom_range(0, 127));
    cols_set[4] = 7'($urandom_range(0, 127));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // full-size matrix, edge rows and columns
    queue_row(CMD_LOAD, 6'd0, '1, '0, 1'b0);
    queue_row(CMD_LOAD, 6'd63, rand_row(), '1, 1'b1);
    queue_row(CMD_LOAD, 6'd1, 64'haaaa_aaaa_aaaa_aaaa, '0, 1'b0);
    queue_row(CMD_LOAD, 6'd2, 64'h8000_0000_0000_0000, '0, 1'b0);
    queue_row(CMD_MUL, 6'd0, '0, '1, 1'b0);
    queue_row(CMD_MUL, 6'd63, 64'd1, '0, 1'b0);
    queue_row(CMD_MUL, 6'd0, 64'h8000_0000_0000_0000, rand_row(), 1'b1);
    queue_row(CMD_MUL, 6'd0, '1, '1, 1'b1);
    queue_row(CMD_MUL, 6'd0, 64'h6, '0, 1'b0);
    drain();

    // no inner bits, column count saturating
    write_reg(CFG_NUM_INNER, 7'd0);
    write_reg(CFG_NUM_COLS, 7'd100);
    queue_row(CMD_MUL, 6'd0, '1, rand_row(), 1'b0);
    queue_row(CMD_MUL, 6'd0, '1, '1, 1'b1);
    drain();

    // inner count saturating, zero columns
    write_reg(CFG_NUM_INNER, 7'd127);
    write_reg(CFG_NUM_COLS, 7'd0);
    queue_row(CMD_LOAD, 6'd5, '1, '0, 1'b0);
    queue_row(CMD_MUL, 6'd0, '1, '1, 1'b1);
    drain();

    // narrow matrix, then widen columns over rows stored narrow
    write_reg(CFG_NUM_INNER, 7'd3);
    write_reg(CFG_NUM_COLS, 7'd8);
    queue_row(CMD_LOAD, 6'd3, '1, '0, 1'b0);
    queue_row(CMD_MUL, 6'd0, '1, '1, 1'b0);
    drain();
    write_reg(CFG_NUM_INNER, 7'd64);
    write_reg(CFG_NUM_COLS, 7'd64);
    queue_row(CMD_MUL, 6'd0, 64'h28, '0, 1'b0);
    queue_row(CMD_MUL, 6'd0, '1, '1, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_NUM_INNER, inner_set[p]);
      write_reg(CFG_NUM_COLS, cols_set[p]);
      idle_mode = mode_set[p];
      random_rows(PHASE_ITEMS);
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/gf2mma_pkg.sv
rtl/core/gf2mma_cell.sv
rtl/core/gf2_matrix_mult_accumulate_top.sv
bench/tb_gf2_matrix_mult_accumulate_top.sv
